// File: rtl/core/color_temperature_to_rgb_macros.svh
// Assertion helpers shared by the colour temperature core.
`ifndef COLOR_TEMPERATURE_TO_RGB_MACROS_SVH
`define COLOR_TEMPERATURE_TO_RGB_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define CTRGB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define CTRGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ctrgb_pkg.sv
`timescale 1ns / 1ps
package ctrgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LOG_STAGES = 16;
	localparam int EXP_STAGES = 16;
	// stage indices of the valid chain
	localparam int ST_LN = LOG_STAGES + 1;
	localparam int ST_PREP = LOG_STAGES + 2;
	localparam int ST_PROD = ST_PREP + EXP_STAGES + 1;

	// Q16 coefficients, rounded to nearest
	localparam logic [25:0] LN2_Q = 26'd45426;
	localparam logic [25:0] C_G1 = 26'd6518919;
	localparam logic signed [31:0] C_G2 = 32'sd10559132;
	localparam logic [25:0] P_R = 26'd8730;
	localparam logic [25:0] C_R = 26'd21607136;
	localparam logic [25:0] P_G = 26'd4949;
	localparam logic [25:0] C_G = 26'd18882375;
	localparam logic [25:0] C_B1 = 26'd9077898;
	localparam logic signed [31:0] C_B2 = 32'sd19991416;

	typedef struct packed {
		logic le6600;
		logic ge6600;
		logic le1900;
		logic zero;
	} range_t;

	// integer square root, elaboration only
	function automatic logic [63:0] isqrt_f(input logic [63:0] v0);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = v0;
		res = 64'd0;
		bt = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (bt > v) bt = bt >> 2;
		end
		for (int s = 0; s < 32; s++) begin
			if (bt != 64'd0) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// Q30 value of 2^(2^-i)
	function automatic logic [63:0] pow_tab_f(input int i);
		logic [63:0] t;
		t = 64'd1 << 31;
		for (int j = 1; j < 25; j++) begin
			if (j <= i) t = isqrt_f(t << 30);
		end
		return t;
	endfunction

	// log2 of a constant integer, Q16, elaboration only
	function automatic logic [63:0] log2_int_f(input logic [63:0] x);
		int k;
		logic [63:0] m;
		logic [63:0] r;
		k = 0;
		for (int s = 0; s < 17; s++) begin
			if (k < 17 && (x >> (k + 1)) != 64'd0) k++;
		end
		m = x << (30 - k);
		r = 64'(k) << FRAC_BITS;
		for (int b = FRAC_BITS - 1; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				r = r | (64'd1 << b);
			end
		end
		return r;
	endfunction

	localparam logic signed [31:0] LOG2_100 = $signed(32'(log2_int_f(64'd100)));

	// constant times signed Q16 value, rounded half away from zero
	function automatic logic signed [31:0] mulc(input logic [25:0] c,
			input logic signed [31:0] v);
		logic [31:0] mag;
		logic [57:0] p;
		logic [41:0] r;
		mag = v[31] ? 32'(-v) : 32'(v);
		p = 58'(c) * 58'(mag);
		r = 42'((p + (58'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		return v[31] ? -$signed(r[31:0]) : $signed(r[31:0]);
	endfunction

	// clamp and round to a byte
	function automatic logic [7:0] to_byte(input logic signed [31:0] v);
		logic [32:0] s;
		logic [16:0] r;
		s = 33'(unsigned'(v)) + (33'd1 << (FRAC_BITS - 1));
		r = 17'(s >> FRAC_BITS);
		if (v <= 0) return 8'd0;
		if (r > 17'd255) return 8'd255;
		return r[7:0];
	endfunction

endpackage

// File: rtl/core/color_temperature_to_rgb.sv
`timescale 1ns / 1ps
// Colour temperature to RGB, blackbody curve fit.
// Request channel: temperature_k with temp_valid, held off by temp_stall.
// Result channel: red, green, blue with rgb_valid, held off by rgb_stall.
// One request in, one result out, in order, one request per cycle while the pipeline is not frozen.
// The depth from acceptance to rgb_valid is set by two chains of
// sixteen dependent multiplies: the log2 fraction by repeated squaring and
// the exp2 product of 2^(2^-i) factors, one multiply per stage.
// Green and blue below 6600 K use ln fits; red and green above 6600 K use
// power fits computed as exp2(-p * log2(x)) scaled by a constant.
// When rgb_stall is high with a result waiting, the whole pipeline freezes
// and temp_stall rises with it; nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is empty after reset and
// takes a request in the first cycle after arst_n rises.
`include "color_temperature_to_rgb_macros.svh"

module color_temperature_to_rgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        temp_valid,
	output logic        temp_stall,
	input  logic [15:0] temperature_k,
	output logic        rgb_valid,
	input  logic        rgb_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	localparam int NL = ctrgb_pkg::LOG_STAGES;
	localparam int NE = ctrgb_pkg::EXP_STAGES;
	localparam int SPR = ctrgb_pkg::ST_PREP;
	localparam int SPD = ctrgb_pkg::ST_PROD;

	logic adv;
	logic v_s [0:SPD];
	ctrgb_pkg::range_t fl_s [0:SPD];

	// log2 pipelines: A for red/green operand, B for blue operand
	logic [30:0] la_m_s [0:NL];
	logic [19:0] la_r_s [0:NL];
	logic [30:0] lb_m_s [0:NL];
	logic [19:0] lb_r_s [0:NL];

	logic signed [31:0] ln_a_s17, ln_b_s17, pr_s17, pg_s17;

	logic signed [31:0] glin_s [SPR:SPD];
	logic signed [31:0] blin_s [SPR:SPD];

	// exp2 pipelines for red and green
	logic [31:0] er_m_s [0:NE];
	logic [15:0] er_f_s [0:NE];
	logic [4:0]  er_n_s [0:NE];
	logic [31:0] eg_m_s [0:NE];
	logic [15:0] eg_f_s [0:NE];
	logic [4:0]  eg_n_s [0:NE];

	logic signed [31:0] rpre_s35, gpre_s35;

	logic [7:0] red_q, green_q, blue_q;
	logic       valid_q;

	// Freeze everything while a finished result is held off.
	assign adv = !(valid_q && rgb_stall);
	assign temp_stall = !adv;
	assign rgb_valid = valid_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;

	// Operand selection and normalisation of the incoming request
	logic [15:0] xa, xb;
	logic [3:0]  ka, kb;
	logic [45:0] sha, shb;
	ctrgb_pkg::range_t fl_in;

	always_comb begin
		fl_in.le6600 = temperature_k <= 16'd6600;
		fl_in.ge6600 = temperature_k >= 16'd6600;
		fl_in.le1900 = temperature_k <= 16'd1900;
		fl_in.zero = temperature_k == 16'd0;
		// above 6600 K the power fits take (t - 60)
		xa = fl_in.le6600 ? temperature_k : temperature_k - 16'd6000;
		// blue takes (t - 10); wraps harmlessly where blue is forced
		xb = temperature_k - 16'd1000;
		ka = 4'd0;
		kb = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (xa[i]) ka = 4'(i);
			if (xb[i]) kb = 4'(i);
		end
		sha = 46'(xa) << (5'd30 - 5'(ka));
		shb = 46'(xb) << (5'd30 - 5'(kb));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= SPD; i++) v_s[i] <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= temp_valid;
			for (int i = 1; i <= SPD; i++) v_s[i] <= v_s[i-1];
			valid_q <= v_s[SPD];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s[0] <= fl_in;
			for (int i = 1; i <= SPD; i++) fl_s[i] <= fl_s[i-1];
			la_m_s[0] <= sha[30:0];
			la_r_s[0] <= 20'(ka) << ctrgb_pkg::FRAC_BITS;
			lb_m_s[0] <= shb[30:0];
			lb_r_s[0] <= 20'(kb) << ctrgb_pkg::FRAC_BITS;
		end
	end

	// One fraction bit per stage: square the mantissa, renormalise.
	for (genvar j = 1; j <= NL; j++) begin : g_log
		logic [61:0] sqa, sqb;
		logic [31:0] ta, tb;
		assign sqa = 62'(la_m_s[j-1]) * 62'(la_m_s[j-1]);
		assign sqb = 62'(lb_m_s[j-1]) * 62'(lb_m_s[j-1]);
		assign ta = sqa[61:30];
		assign tb = sqb[61:30];
		always_ff @(posedge clk) begin
			if (adv) begin
				la_m_s[j] <= ta[31] ? ta[31:1] : ta[30:0];
				la_r_s[j] <= la_r_s[j-1] | (ta[31] ? (20'd1 << (NL - j)) : 20'd0);
				lb_m_s[j] <= tb[31] ? tb[31:1] : tb[30:0];
				lb_r_s[j] <= lb_r_s[j-1] | (tb[31] ? (20'd1 << (NL - j)) : 20'd0);
			end
		end
	end

	// log2(x/100), then ln and the power exponents
	logic signed [31:0] l_a, l_b;
	assign l_a = $signed({12'd0, la_r_s[NL]}) - ctrgb_pkg::LOG2_100;
	assign l_b = $signed({12'd0, lb_r_s[NL]}) - ctrgb_pkg::LOG2_100;

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_a_s17 <= ctrgb_pkg::mulc(ctrgb_pkg::LN2_Q, l_a);
			ln_b_s17 <= ctrgb_pkg::mulc(ctrgb_pkg::LN2_Q, l_b);
			pr_s17 <= ctrgb_pkg::mulc(ctrgb_pkg::P_R, l_a);
			pg_s17 <= ctrgb_pkg::mulc(ctrgb_pkg::P_G, l_a);
		end
	end

	// Split the negated exponent into whole shift and fraction complement.
	logic [19:0] ar, ag;
	logic [15:0] frr, frg;
	always_comb begin
		ar = (pr_s17 > 0) ? pr_s17[19:0] : 20'd0;
		ag = (pg_s17 > 0) ? pg_s17[19:0] : 20'd0;
		frr = ar[15:0];
		frg = ag[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			glin_s[SPR] <= ctrgb_pkg::mulc(ctrgb_pkg::C_G1, ln_a_s17) - ctrgb_pkg::C_G2;
			blin_s[SPR] <= ctrgb_pkg::mulc(ctrgb_pkg::C_B1, ln_b_s17) - ctrgb_pkg::C_B2;
			for (int i = SPR + 1; i <= SPD; i++) begin
				glin_s[i] <= glin_s[i-1];
				blin_s[i] <= blin_s[i-1];
			end
			er_m_s[0] <= 32'd1 << 30;
			er_n_s[0] <= {1'b0, ar[19:16]} + 5'(frr != 16'd0);
			er_f_s[0] <= (frr != 16'd0) ? 16'(17'h10000 - 17'(frr)) : 16'd0;
			eg_m_s[0] <= 32'd1 << 30;
			eg_n_s[0] <= {1'b0, ag[19:16]} + 5'(frg != 16'd0);
			eg_f_s[0] <= (frg != 16'd0) ? 16'(17'h10000 - 17'(frg)) : 16'd0;
		end
	end

	// One fraction bit per stage: multiply in 2^(2^-k) where the bit is set.
	for (genvar i = 1; i <= NE; i++) begin : g_exp
		localparam logic [31:0] TABV = 32'(ctrgb_pkg::pow_tab_f(NE + 1 - i));
		logic [63:0] pr_r, pr_g;
		assign pr_r = 64'(er_m_s[i-1]) * 64'(TABV) + (64'd1 << 29);
		assign pr_g = 64'(eg_m_s[i-1]) * 64'(TABV) + (64'd1 << 29);
		always_ff @(posedge clk) begin
			if (adv) begin
				er_m_s[i] <= er_f_s[i-1][i-1] ? pr_r[61:30] : er_m_s[i-1];
				eg_m_s[i] <= eg_f_s[i-1][i-1] ? pr_g[61:30] : eg_m_s[i-1];
				er_f_s[i] <= er_f_s[i-1];
				eg_f_s[i] <= eg_f_s[i-1];
				er_n_s[i] <= er_n_s[i-1];
				eg_n_s[i] <= eg_n_s[i-1];
			end
		end
	end

	// Drop the Q30 mantissa to Q16 after the whole shift, then scale.
	logic [17:0] exp_r, exp_g;
	assign exp_r = 18'((er_m_s[NE] >> er_n_s[NE]) >> 14);
	assign exp_g = 18'((eg_m_s[NE] >> eg_n_s[NE]) >> 14);

	always_ff @(posedge clk) begin
		if (adv) begin
			rpre_s35 <= ctrgb_pkg::mulc(ctrgb_pkg::C_R, $signed({14'd0, exp_r}));
			gpre_s35 <= ctrgb_pkg::mulc(ctrgb_pkg::C_G, $signed({14'd0, exp_g}));
		end
	end

	// Pick the branch per channel and clamp to a byte.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (fl_s[SPD].le6600) begin
				red_q <= 8'd255;
				green_q <= fl_s[SPD].zero ? 8'd0 : ctrgb_pkg::to_byte(glin_s[SPD]);
			end else begin
				red_q <= ctrgb_pkg::to_byte(rpre_s35);
				green_q <= ctrgb_pkg::to_byte(gpre_s35);
			end
			if (fl_s[SPD].ge6600) begin
				blue_q <= 8'd255;
			end else if (fl_s[SPD].le1900) begin
				blue_q <= 8'd0;
			end else begin
				blue_q <= ctrgb_pkg::to_byte(blin_s[SPD]);
			end
		end
	end

	`CTRGB_ASSERT_NEXT(a_last_stage_moves, v_s[SPD] && adv, rgb_valid, "result lost at output stage")
	`CTRGB_ASSERT_NEXT(a_freeze_holds, rgb_valid && rgb_stall, $stable(v_s[SPD]) && $stable(v_s[0]), "pipeline moved while held")
	`CTRGB_ASSERT_NOW(a_warm_red, rgb_valid && $past(adv) && $past(fl_s[SPD].le6600), red_q == 8'd255, "red not full at or below 6600 K")
	`CTRGB_ASSERT_NOW(a_cold_blue, rgb_valid && $past(adv) && $past(fl_s[SPD].le1900), blue_q == 8'd0, "blue not zero at or below 1900 K")

endmodule

// File: sim/tb_color_temperature_to_rgb.sv
`timescale 1ns / 1ps
module tb_color_temperature_to_rgb;

	// Result of one colour temperature request.
	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam int QF = 16;
	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned BILLION = 64'd1000000000;

	logic        clk;
	logic        arst_n;
	logic        temp_valid;
	logic        temp_stall;
	logic [15:0] temperature_k;
	logic        rgb_valid;
	logic        rgb_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	rgb_t            pending_rgb[$];
	longint unsigned root_tab[25];
	int              fail_count = 0;
	bit              calm = 0;   // no idling on either side while set

	color_temperature_to_rgb dut (
		.clk(clk), .arst_n(arst_n),
		.temp_valid(temp_valid), .temp_stall(temp_stall), .temperature_k(temperature_k),
		.rgb_valid(rgb_valid), .rgb_stall(rgb_stall),
		.red(red), .green(green), .blue(blue)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// ---------------------------------------------------------------
	// Fixed-point predictor: Q16 intermediates, log2 by squaring,
	// exp2 as a product of 2^(2^-i) factors.
	// ---------------------------------------------------------------
	function automatic longint unsigned int_sqrt(input longint unsigned v0);
		longint unsigned v, res, bt;
		v = v0; res = 0; bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	// decimal constant in units of 1e-9 to Q16, rounded
	function automatic longint to_q(input longint unsigned n);
		return longint'(((n << QF) + BILLION / 2) / BILLION);
	endfunction

	// product with rounding half away from zero
	function automatic longint mul_q(input longint a, input longint b);
		longint unsigned ua, ub, p;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? longint'(-a) : a;
		ub = b < 0 ? longint'(-b) : b;
		p = (ua * ub + (64'd1 << (QF - 1))) >> QF;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint log2_q(input longint unsigned x);
		int k;
		longint unsigned m, r;
		k = 0;
		while (k < 17 && (x >> (k + 1)) != 0) k++;
		m = x << (30 - k);
		r = longint'(k) << QF;
		for (int b = QF - 1; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 2 * Q30) begin
				m >>= 1;
				r |= 64'd1 << b;
			end
		end
		return longint'(r);
	endfunction

	// 2^e for e <= 0
	function automatic longint pow2_neg(input longint e);
		longint unsigned a, n, f, m;
		a = e < 0 ? longint'(-e) : 0;
		n = a >> QF;
		f = a & ((64'd1 << QF) - 1);
		m = Q30;
		if (f != 0) begin
			n++;
			f = (64'd1 << QF) - f;
		end
		for (int b = 0; b < QF; b++)
			if ((f >> b) & 1)
				m = (m * root_tab[QF - b] + Q30 / 2) >> 30;
		if (n >= 62) return 0;
		m >>= n;
		return longint'(m >> (30 - QF));
	endfunction

	function automatic logic [7:0] clamp_byte(input longint v);
		longint unsigned r;
		if (v <= 0) return 8'd0;
		r = (longint'(v) + (64'd1 << (QF - 1))) >> QF;
		return r > 255 ? 8'd255 : r[7:0];
	endfunction

	// ln(x/100)
	function automatic longint ln_hundredths(input longint unsigned x);
		return mul_q(to_q(64'd693147181), log2_q(x) - log2_q(100));
	endfunction

	// c * (x/100)^-p
	function automatic longint power_fit(input longint unsigned x,
			input longint unsigned p_n, input longint unsigned c_n);
		longint l;
		l = log2_q(x) - log2_q(100);
		return mul_q(to_q(c_n), pow2_neg(-mul_q(to_q(p_n), l)));
	endfunction

	function automatic rgb_t kelvin_to_rgb(input logic [15:0] k);
		rgb_t o;
		if (k <= 6600) begin
			o.red = 8'd255;
			if (k == 0)
				o.green = 8'd0;
			else
				o.green = clamp_byte(mul_q(to_q(64'd99470802586), ln_hundredths(k))
						- to_q(64'd161119568166));
		end else begin
			o.red = clamp_byte(power_fit(k - 6000, 64'd133204759, 64'd329698727446));
			o.green = clamp_byte(power_fit(k - 6000, 64'd75514849, 64'd288122169528));
		end
		if (k >= 6600)
			o.blue = 8'd255;
		else if (k <= 1900)
			o.blue = 8'd0;
		else
			o.blue = clamp_byte(mul_q(to_q(64'd138517731223), ln_hundredths(k - 1000))
					- to_q(64'd305044792731));
		return o;
	endfunction

	// ---------------------------------------------------------------
	// Request side: drive at the falling edge, accept at the rising edge.
	// Valid stays high between back-to-back requests.
	// ---------------------------------------------------------------
	task automatic send_kelvin(input logic [15:0] k);
		if (!calm && $urandom_range(99) < 9) begin
			temp_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 30);
		end
		temp_valid <= 1'b1;
		temperature_k <= k;
		forever begin
			@(posedge clk);
			if (!temp_stall) break;
		end
		pending_rgb.push_back(kelvin_to_rgb(k));
		@(negedge clk);
	endtask

	// Result side: stall at random unless the quiet stretch is on.
	always @(negedge clk)
		rgb_stall <= !calm && ($urandom_range(99) < 9);

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		rgb_t exp_rgb;
		if (arst_n && rgb_valid && !rgb_stall) begin
			if (pending_rgb.size() == 0) begin
				$error("result with no request outstanding: %0d %0d %0d", red, green, blue);
				fail_count++;
			end else begin
				exp_rgb = pending_rgb.pop_front();
				if (red !== exp_rgb.red) begin
					$error("red: expected %0d, got %0d", exp_rgb.red, red);
					fail_count++;
				end
				if (green !== exp_rgb.green) begin
					$error("green: expected %0d, got %0d", exp_rgb.green, green);
					fail_count++;
				end
				if (blue !== exp_rgb.blue) begin
					$error("blue: expected %0d, got %0d", exp_rgb.blue, blue);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Field extremes, zero kelvin, sub-100 K and every curve boundary.
	task automatic test_boundaries();
		logic [15:0] pts[] = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd1000,
			16'd1899, 16'd1900, 16'd1901, 16'd2000, 16'd4000, 16'd6000,
			16'd6599, 16'd6600, 16'd6601, 16'd6700, 16'd10000, 16'd40000,
			16'd32768, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA};
		foreach (pts[i]) send_kelvin(pts[i]);
	endtask

	// Full back-pressure free stretch at one request per cycle.
	task automatic test_streaming(input int n);
		calm = 1;
		repeat (n) send_kelvin(16'($urandom_range(1000, 12000)));
		calm = 0;
	endtask

	// Mostly the interesting range, some across the whole field.
	task automatic test_random(input int n);
		repeat (n) begin
			case ($urandom_range(3))
				0: send_kelvin(16'($urandom));
				1: send_kelvin(16'($urandom_range(0, 2000)));
				2: send_kelvin(16'($urandom_range(6400, 6800)));
				default: send_kelvin(16'($urandom_range(1000, 20000)));
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < 25; i++)
			root_tab[i] = (i == 0) ? 2 * Q30 : int_sqrt(root_tab[i - 1] << 30);
		arst_n = 1'b0;
		temp_valid = 1'b0;
		temperature_k = 16'd0;
		rgb_stall = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_boundaries();
		test_random(600);
		test_streaming(200);
		test_random(430);

		// drain, then give the pipeline time to show any stray result
		temp_valid <= 1'b0;
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#3ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
